// ===== rtl/core/ita_pkg.sv =====
// Shared types, constants and helpers for the integer-to-ASCII field formatter.
package ita_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_FIELD  = 48;
    localparam int MAX_DIGITS = 32;

    localparam int RADIX_W  = 6;
    localparam int FLAGS_W  = 7;
    localparam int CHAR_W   = 8;

    // Divider retires this many quotient bits per cycle.
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam int ND_W  = $clog2(VALUE_BITS + 1);
    localparam int CNT_W = $clog2(MAX_FIELD + VALUE_BITS + MAX_DIGITS + 4);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_OCT = RADIX_W'(8);
    localparam logic [RADIX_W-1:0] RADIX_HEX = RADIX_W'(16);

    // Bit positions in format_flags.
    localparam int FL_ZERO   = 0;
    localparam int FL_SIGNED = 1;
    localparam int FL_PLUS   = 2;
    localparam int FL_SPACE  = 3;
    localparam int FL_LEFT   = 4;
    localparam int FL_PREFIX = 5;
    localparam int FL_UPPER  = 6;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

    typedef struct packed {
        logic [31:0]        value;
        logic [RADIX_W-1:0] radix;
        logic [5:0]         fld_width;
        logic [5:0]         min_digits;
        logic [FLAGS_W-1:0] format_flags;
    } t_fmt_req;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
        logic              bad_radix;
    } t_fmt_res;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_cmd;

    // Digit value (always below the radix, so below 36) to ASCII.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] ch;
        if (d < RADIX_W'(10)) begin
            ch = CH_ZERO + CHAR_W'(d);
        end else if (upper) begin
            ch = CH_UP_A + CHAR_W'(d) - CHAR_W'(10);
        end else begin
            ch = CH_LO_A + CHAR_W'(d) - CHAR_W'(10);
        end
        return ch;
    endfunction

endpackage

// ===== rtl/core/ita_div.sv =====
// Iterative restoring divider: value by radix, DIV_BITS quotient bits per cycle.
module ita_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [ita_pkg::VALUE_BITS-1:0]      i_dividend,
    input  logic [ita_pkg::RADIX_W-1:0]         i_divisor,
    output logic                                o_done,
    output logic [ita_pkg::VALUE_BITS-1:0]      o_quot,
    output logic [ita_pkg::RADIX_W-1:0]         o_rem
);

    logic [ita_pkg::DIV_W-1:0]   r_q,   n_q;
    logic [ita_pkg::RADIX_W-1:0] r_rem, n_rem;
    logic [ita_pkg::RADIX_W-1:0] r_div;
    logic [ita_pkg::STEP_W-1:0]  r_cnt;
    logic                        r_done;

    // DIV_BITS chained compare/subtract steps on a 7-bit partial remainder.
    always_comb begin
        logic [ita_pkg::RADIX_W:0] trial;
        n_q   = r_q;
        n_rem = r_rem;
        for (int k = 0; k < ita_pkg::DIV_BITS; k++) begin
            trial = {n_rem, n_q[ita_pkg::DIV_W-1]};
            n_q   = {n_q[ita_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial  = trial - {1'b0, r_div};
                n_q[0] = 1'b1;
            end
            n_rem = trial[ita_pkg::RADIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= ita_pkg::STEP_W'(ita_pkg::DIV_STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == ita_pkg::STEP_W'(1));
        end else begin
            r_done <= 1'b0;
        end

        if (i_start) begin
            r_q   <= ita_pkg::DIV_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q[ita_pkg::VALUE_BITS-1:0];
    assign o_rem  = r_rem;

endmodule

// ===== rtl/core/ita_stack.sv =====
// Digit LIFO: digits arrive least significant first and leave most significant first.
module ita_stack (
    input  logic                         i_clk,
    input  ita_pkg::t_stk_cmd            i_cmd,
    input  logic [ita_pkg::RADIX_W-1:0]  i_digit,
    output logic [ita_pkg::RADIX_W-1:0]  o_top
);

    logic [ita_pkg::RADIX_W-1:0] r_stk [ita_pkg::VALUE_BITS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stk[0] <= i_digit;
            for (int i = 1; i < ita_pkg::VALUE_BITS; i++) begin
                r_stk[i] <= r_stk[i-1];
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < ita_pkg::VALUE_BITS - 1; i++) begin
                r_stk[i] <= r_stk[i+1];
            end
        end
    end

    assign o_top = r_stk[0];

endmodule

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// Top level: printf-style integer field formatter with digit sequencer and emitter.
//
// One request is taken when start is high and busy is low; busy then stays high
// until the last character of the field has been registered. Characters leave one
// per cycle on o_res, marked by o_strobe, and the receiver must take each one in
// that cycle. A request with a radix outside 2..36 yields one error result in the
// next cycle and keeps busy low. Otherwise each digit comes from one pass of the
// shared divider, which retires 4 quotient bits a cycle, and the emitter then
// sends one character a cycle.
module integer_to_ascii_formatter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ita_pkg::t_fmt_req i_req,
    output logic              o_strobe,
    output ita_pkg::t_fmt_res o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSTART,
        S_DWAIT,
        S_LAY1,
        S_LAY2,
        S_EMIT
    } t_state;

    localparam int CW = ita_pkg::CNT_W;
    localparam int VB = ita_pkg::VALUE_BITS;
    localparam int RW = ita_pkg::RADIX_W;
    localparam int NW = ita_pkg::ND_W;

    t_state r_state, n_state;

    logic [VB-1:0]              r_mag, n_mag;
    logic [RW-1:0]              r_radix, n_radix;
    logic [CW-1:0]              r_width, n_width;
    logic [CW-1:0]              r_prec, n_prec;
    logic                       r_zero, n_zero;
    logic                       r_left, n_left;
    logic                       r_upper, n_upper;
    logic                       r_has_sign, n_has_sign;
    logic [ita_pkg::CHAR_W-1:0] r_sign_ch, n_sign_ch;
    logic [1:0]                 r_pfx, n_pfx;
    logic [NW-1:0]              r_nd, n_nd;
    logic [CW-1:0]              r_body, n_body;
    logic [CW-1:0]              r_content, n_content;
    logic [CW-1:0]              r_b_lsp, n_b_lsp;
    logic [CW-1:0]              r_b_sign, n_b_sign;
    logic [CW-1:0]              r_b_pfx, n_b_pfx;
    logic [CW-1:0]              r_b_zero, n_b_zero;
    logic [CW-1:0]              r_b_dig, n_b_dig;
    logic [CW-1:0]              r_end, n_end;
    logic [CW-1:0]              r_pos, n_pos;
    logic                       r_strobe, n_strobe;
    ita_pkg::t_fmt_res          r_res, n_res;

    logic                       div_start;
    logic                       div_done;
    logic [VB-1:0]              div_quot;
    logic [RW-1:0]              div_rem;
    ita_pkg::t_stk_cmd          stk_cmd;
    logic [RW-1:0]              stk_top;

    ita_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_radix),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    ita_stack u_stack (
        .i_clk   (i_clk),
        .i_cmd   (stk_cmd),
        .i_digit (div_rem),
        .o_top   (stk_top)
    );

    assign div_start = (r_state == S_DSTART);
    assign busy      = (r_state != S_IDLE);

    always_comb begin
        logic [VB-1:0] raw;
        logic [CW-1:0] pad;
        logic [CW-1:0] tot;
        logic [CW-1:0] nd_ext;

        n_state    = r_state;
        n_mag      = r_mag;
        n_radix    = r_radix;
        n_width    = r_width;
        n_prec     = r_prec;
        n_zero     = r_zero;
        n_left     = r_left;
        n_upper    = r_upper;
        n_has_sign = r_has_sign;
        n_sign_ch  = r_sign_ch;
        n_pfx      = r_pfx;
        n_nd       = r_nd;
        n_body     = r_body;
        n_content  = r_content;
        n_b_lsp    = r_b_lsp;
        n_b_sign   = r_b_sign;
        n_b_pfx    = r_b_pfx;
        n_b_zero   = r_b_zero;
        n_b_dig    = r_b_dig;
        n_end      = r_end;
        n_pos      = r_pos;
        n_strobe   = 1'b0;
        n_res      = r_res;
        stk_cmd    = '0;
        raw        = VB'(i_req.value);
        nd_ext     = CW'(r_nd);
        pad        = '0;
        tot        = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (!(i_req.radix inside {[ita_pkg::RADIX_MIN:ita_pkg::RADIX_MAX]})) begin
                        n_strobe = 1'b1;
                        n_res    = '{out_char: ita_pkg::CH_NUL, last: 1'b1, bad_radix: 1'b1};
                    end else begin
                        n_state = S_DSTART;
                        n_radix = i_req.radix;
                        n_left  = i_req.format_flags[ita_pkg::FL_LEFT];
                        n_zero  = i_req.format_flags[ita_pkg::FL_ZERO]
                                  && !i_req.format_flags[ita_pkg::FL_LEFT];
                        n_upper = i_req.format_flags[ita_pkg::FL_UPPER];
                        n_width = (CW'(i_req.fld_width) > CW'(ita_pkg::MAX_FIELD))
                                  ? CW'(ita_pkg::MAX_FIELD) : CW'(i_req.fld_width);
                        n_prec  = (CW'(i_req.min_digits) > CW'(ita_pkg::MAX_DIGITS))
                                  ? CW'(ita_pkg::MAX_DIGITS) : CW'(i_req.min_digits);
                        n_nd    = '0;
                        n_mag   = raw;
                        n_has_sign = 1'b0;
                        n_sign_ch  = ita_pkg::CH_SPACE;
                        if (i_req.format_flags[ita_pkg::FL_SIGNED]) begin
                            if (raw[VB-1]) begin
                                n_has_sign = 1'b1;
                                n_sign_ch  = ita_pkg::CH_MINUS;
                                n_mag      = '0 - raw;
                            end else if (i_req.format_flags[ita_pkg::FL_PLUS]) begin
                                n_has_sign = 1'b1;
                                n_sign_ch  = ita_pkg::CH_PLUS;
                            end else if (i_req.format_flags[ita_pkg::FL_SPACE]) begin
                                n_has_sign = 1'b1;
                                n_sign_ch  = ita_pkg::CH_SPACE;
                            end
                        end
                        n_pfx = 2'd0;
                        if (i_req.format_flags[ita_pkg::FL_PREFIX]) begin
                            if (i_req.radix == ita_pkg::RADIX_HEX) begin
                                n_pfx = 2'd2;
                            end else if (i_req.radix == ita_pkg::RADIX_OCT) begin
                                n_pfx = 2'd1;
                            end
                        end
                    end
                end
            end
            S_DSTART: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_done) begin
                    stk_cmd.push = 1'b1;
                    n_nd         = r_nd + 1'b1;
                    n_mag        = div_quot;
                    n_state      = (div_quot == '0) ? S_LAY1 : S_DSTART;
                end
            end
            S_LAY1: begin
                n_body    = (nd_ext > r_prec) ? nd_ext : r_prec;
                n_content = CW'(r_has_sign) + CW'(r_pfx) + n_body;
                n_state   = S_LAY2;
            end
            S_LAY2: begin
                pad      = (r_width > r_content) ? (r_width - r_content) : '0;
                n_b_lsp  = (r_left || r_zero) ? '0 : pad;
                n_b_sign = n_b_lsp + CW'(r_has_sign);
                n_b_pfx  = n_b_sign + CW'(r_pfx);
                n_b_zero = n_b_pfx + (r_zero ? pad : '0) + (r_body - nd_ext);
                n_b_dig  = n_b_zero + nd_ext;
                tot      = n_b_dig + (r_left ? pad : '0);
                n_end    = (tot > CW'(ita_pkg::MAX_FIELD)) ? CW'(ita_pkg::MAX_FIELD) : tot;
                n_pos    = '0;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                n_strobe        = 1'b1;
                n_res.bad_radix = 1'b0;
                n_res.last      = (r_pos == r_end - 1'b1);
                if (r_pos < r_b_lsp) begin
                    n_res.out_char = ita_pkg::CH_SPACE;
                end else if (r_pos < r_b_sign) begin
                    n_res.out_char = r_sign_ch;
                end else if (r_pos < r_b_pfx) begin
                    // prefix: "0", then x/X for hex
                    if (r_pos == r_b_sign) begin
                        n_res.out_char = ita_pkg::CH_ZERO;
                    end else begin
                        n_res.out_char = r_upper ? ita_pkg::CH_UP_X : ita_pkg::CH_LO_X;
                    end
                end else if (r_pos < r_b_zero) begin
                    n_res.out_char = ita_pkg::CH_ZERO;
                end else if (r_pos < r_b_dig) begin
                    n_res.out_char = ita_pkg::digit_char(stk_top, r_upper);
                    stk_cmd.pop    = 1'b1;
                end else begin
                    n_res.out_char = ita_pkg::CH_SPACE;
                end
                n_pos = r_pos + 1'b1;
                if (n_res.last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_mag      <= n_mag;
        r_radix    <= n_radix;
        r_width    <= n_width;
        r_prec     <= n_prec;
        r_zero     <= n_zero;
        r_left     <= n_left;
        r_upper    <= n_upper;
        r_has_sign <= n_has_sign;
        r_sign_ch  <= n_sign_ch;
        r_pfx      <= n_pfx;
        r_nd       <= n_nd;
        r_body     <= n_body;
        r_content  <= n_content;
        r_b_lsp    <= n_b_lsp;
        r_b_sign   <= n_b_sign;
        r_b_pfx    <= n_b_pfx;
        r_b_zero   <= n_b_zero;
        r_b_dig    <= n_b_dig;
        r_end      <= n_end;
        r_pos      <= n_pos;
        r_res      <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ===== rtl/core/ita_checker.sv =====
// Port-level checker for the formatter, bound to the top level.
module ita_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input ita_pkg::t_fmt_req i_req,
    input logic              o_strobe,
    input ita_pkg::t_fmt_res o_res
);

    logic radix_ok;
    assign radix_ok = (i_req.radix >= ita_pkg::RADIX_MIN) && (i_req.radix <= ita_pkg::RADIX_MAX);

    a_idle_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy set right after reset");

    a_bad_radix_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !radix_ok |=> o_strobe && o_res.bad_radix && o_res.last
                                        && (o_res.out_char == ita_pkg::CH_NUL) && !busy)
        else $error("bad radix request not answered by a single error result");

    a_good_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && radix_ok |=> busy && !o_strobe)
        else $error("valid request did not start a field");

    a_more_chars_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_res.last |-> busy && !o_res.bad_radix)
        else $error("non-final character while idle");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the integer-to-ASCII field formatter.
module tb;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES   = 400;

    localparam logic [ita_pkg::FLAGS_W-1:0] F_ZERO   =
        ita_pkg::FLAGS_W'(1) << ita_pkg::FL_ZERO;
    localparam logic [ita_pkg::FLAGS_W-1:0] F_SIGNED =
        ita_pkg::FLAGS_W'(1) << ita_pkg::FL_SIGNED;
    localparam logic [ita_pkg::FLAGS_W-1:0] F_PLUS   =
        ita_pkg::FLAGS_W'(1) << ita_pkg::FL_PLUS;
    localparam logic [ita_pkg::FLAGS_W-1:0] F_SPACE  =
        ita_pkg::FLAGS_W'(1) << ita_pkg::FL_SPACE;
    localparam logic [ita_pkg::FLAGS_W-1:0] F_LEFT   =
        ita_pkg::FLAGS_W'(1) << ita_pkg::FL_LEFT;
    localparam logic [ita_pkg::FLAGS_W-1:0] F_PREFIX =
        ita_pkg::FLAGS_W'(1) << ita_pkg::FL_PREFIX;
    localparam logic [ita_pkg::FLAGS_W-1:0] F_UPPER  =
        ita_pkg::FLAGS_W'(1) << ita_pkg::FL_UPPER;

    typedef struct {
        ita_pkg::t_fmt_req req;
        int unsigned       idle_pct;
    } t_queued_req;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    ita_pkg::t_fmt_req i_req   = '0;
    logic              o_strobe;
    ita_pkg::t_fmt_res o_res;

    t_queued_req       pending_reqs[$];
    ita_pkg::t_fmt_res expected_chars[$];
    int unsigned       mismatch_count = 0;
    int unsigned       quiet_cycles   = 0;

    integer_to_ascii_formatter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Builds the expected character stream of one request.
    function automatic void format_field(input ita_pkg::t_fmt_req r);
        string                       lo_set = "0123456789abcdefghijklmnopqrstuvwxyz";
        string                       up_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
        logic [31:0]                 mag;
        logic [31:0]                 base;
        logic [31:0]                 d;
        logic [ita_pkg::FLAGS_W-1:0] fl;
        logic [7:0]                  sign_ch;
        logic [7:0]                  digs[$];
        logic [7:0]                  field[$];
        int unsigned                 width, prec, nd, body, content, pad, pfx;
        ita_pkg::t_fmt_res           res;

        if (r.radix < ita_pkg::RADIX_MIN || r.radix > ita_pkg::RADIX_MAX) begin
            res.out_char  = ita_pkg::CH_NUL;
            res.last      = 1'b1;
            res.bad_radix = 1'b1;
            expected_chars.push_back(res);
            return;
        end
        mag  = r.value;
        base = 32'(r.radix);
        fl   = r.format_flags;
        if (fl[ita_pkg::FL_LEFT])
            fl[ita_pkg::FL_ZERO] = 1'b0;
        width = (r.fld_width > ita_pkg::MAX_FIELD) ? ita_pkg::MAX_FIELD : r.fld_width;
        prec  = (r.min_digits > ita_pkg::MAX_DIGITS) ? ita_pkg::MAX_DIGITS : r.min_digits;

        sign_ch = ita_pkg::CH_NUL;
        if (fl[ita_pkg::FL_SIGNED]) begin
            if (mag[ita_pkg::VALUE_BITS-1]) begin
                sign_ch = ita_pkg::CH_MINUS;
                mag     = 32'd0 - mag;  // most negative wraps to its own magnitude
            end else if (fl[ita_pkg::FL_PLUS]) begin
                sign_ch = ita_pkg::CH_PLUS;
            end else if (fl[ita_pkg::FL_SPACE]) begin
                sign_ch = ita_pkg::CH_SPACE;
            end
        end
        pfx = 0;
        if (fl[ita_pkg::FL_PREFIX]) begin
            if (r.radix == ita_pkg::RADIX_HEX)
                pfx = 2;
            else if (r.radix == ita_pkg::RADIX_OCT)
                pfx = 1;
        end

        do begin
            d = mag % base;
            digs.push_front(fl[ita_pkg::FL_UPPER] ? up_set[d] : lo_set[d]);
            mag = mag / base;
        end while (mag != 0);

        nd      = digs.size();
        body    = (nd > prec) ? nd : prec;
        content = ((sign_ch != ita_pkg::CH_NUL) ? 1 : 0) + pfx + body;
        pad     = (width > content) ? width - content : 0;

        if (!fl[ita_pkg::FL_LEFT] && !fl[ita_pkg::FL_ZERO])
            repeat (pad) field.push_back(ita_pkg::CH_SPACE);
        if (sign_ch != ita_pkg::CH_NUL)
            field.push_back(sign_ch);
        if (pfx >= 1)
            field.push_back(ita_pkg::CH_ZERO);
        if (pfx == 2)
            field.push_back(fl[ita_pkg::FL_UPPER] ? ita_pkg::CH_UP_X : ita_pkg::CH_LO_X);
        if (fl[ita_pkg::FL_ZERO])
            repeat (pad) field.push_back(ita_pkg::CH_ZERO);
        repeat (body - nd) field.push_back(ita_pkg::CH_ZERO);
        foreach (digs[i])
            field.push_back(digs[i]);
        if (fl[ita_pkg::FL_LEFT])
            repeat (pad) field.push_back(ita_pkg::CH_SPACE);
        while (field.size() > ita_pkg::MAX_FIELD)
            void'(field.pop_back());

        foreach (field[i]) begin
            res.out_char  = field[i];
            res.last      = (i == field.size() - 1);
            res.bad_radix = 1'b0;
            expected_chars.push_back(res);
        end
    endfunction

    task automatic queue_request(input logic [31:0] value,
                                 input logic [ita_pkg::RADIX_W-1:0] radix,
                                 input logic [5:0] fld_width, input logic [5:0] min_digits,
                                 input logic [ita_pkg::FLAGS_W-1:0] format_flags,
                                 input int unsigned idle_pct);
        t_queued_req slot;
        slot.req.value        = value;
        slot.req.radix        = radix;
        slot.req.fld_width    = fld_width;
        slot.req.min_digits   = min_digits;
        slot.req.format_flags = format_flags;
        slot.idle_pct         = idle_pct;
        pending_reqs.push_back(slot);
    endtask

    // Request driver: holds start until the request is taken.
    always @(posedge i_clk) begin
        t_queued_req slot;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                format_field(i_req);
            if (!start || !busy) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= pending_reqs[0].idle_pct) begin
                    slot = pending_reqs.pop_front();
                    i_req <= slot.req;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Character monitor.
    always @(posedge i_clk) begin
        ita_pkg::t_fmt_res want;
        if (i_rst_n && o_strobe) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_res);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                if (o_res.out_char !== want.out_char) begin
                    $display("%0t: out_char expected %h got %h", $time,
                             want.out_char, o_res.out_char);
                    mismatch_count++;
                end
                if (o_res.last !== want.last) begin
                    $display("%0t: last expected %b got %b", $time, want.last, o_res.last);
                    mismatch_count++;
                end
                if (o_res.bad_radix !== want.bad_radix) begin
                    $display("%0t: bad_radix expected %b got %b", $time,
                             want.bad_radix, o_res.bad_radix);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no request or character moving.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int unsigned                 phase_idle[4];
        int unsigned                 pct;
        int unsigned                 sel;
        logic [31:0]                 val;
        logic [ita_pkg::RADIX_W-1:0] rad;

        // sender idle percentage per random phase; receiver cannot stall
        phase_idle = '{0, 74, 0, 24};

        queue_request(32'd0, 6'd10, 6'd0, 6'd0, '0, 0);
        queue_request(32'd0, ita_pkg::RADIX_OCT, 6'd0, 6'd0, F_PREFIX, 0);
        queue_request(32'd0, ita_pkg::RADIX_HEX, 6'd0, 6'd0, F_PREFIX | F_UPPER, 0);
        queue_request(32'hFFFF_FFFF, 6'd2, 6'd48, 6'd0, '0, 0);
        queue_request(32'h8000_0000, 6'd10, 6'd0, 6'd0, F_SIGNED, 0);
        queue_request(32'd12345, 6'd10, 6'd8, 6'd0, F_SIGNED | F_PLUS, 0);
        queue_request(32'd12345, 6'd10, 6'd8, 6'd0, F_SIGNED | F_SPACE, 0);
        queue_request(32'd12345, 6'd10, 6'd8, 6'd0, F_SIGNED | F_PLUS | F_SPACE, 0);
        queue_request(32'd12345, 6'd10, 6'd8, 6'd0, F_PLUS | F_SPACE, 0);
        queue_request(32'hFFFF_FFFF, 6'd10, 6'd12, 6'd0, F_SIGNED | F_ZERO, 0);
        queue_request(32'hDEAD_BEEF, ita_pkg::RADIX_HEX, 6'd20, 6'd0,
                      F_ZERO | F_PREFIX | F_UPPER, 0);
        queue_request(32'hDEAD_BEEF, ita_pkg::RADIX_HEX, 6'd20, 6'd0,
                      F_ZERO | F_LEFT | F_PREFIX, 0);
        queue_request(32'o777, ita_pkg::RADIX_OCT, 6'd10, 6'd6, F_PREFIX | F_LEFT, 0);
        queue_request(32'd1, 6'd2, 6'd0, 6'd32, '0, 0);
        queue_request(32'd42, 6'd10, 6'd63, 6'd63, F_SIGNED | F_PLUS, 0);
        queue_request(32'hFFFF_FFFF, ita_pkg::RADIX_MAX, 6'd0, 6'd0, F_UPPER, 0);
        queue_request(32'hFFFF_FFFF, ita_pkg::RADIX_MAX, 6'd0, 6'd0, '0, 0);
        queue_request(32'd5, 6'd0, 6'd10, 6'd3, '0, 0);
        queue_request(32'd5, 6'd1, 6'd0, 6'd0, F_SIGNED, 0);
        queue_request(32'd5, 6'd37, 6'd0, 6'd0, '0, 0);
        queue_request(32'hFFFF_FFFF, 6'd63, 6'd63, 6'd63, '1, 0);
        queue_request(32'h7FFF_FFFF, 6'd10, 6'd0, 6'd0, F_SIGNED | F_SPACE, 0);
        queue_request(32'd0, 6'd10, 6'd5, 6'd0, F_SIGNED | F_SPACE | F_ZERO, 0);
        queue_request(32'd100, 6'd3, 6'd16, 6'd10, '1, 0);

        for (int k = 0; k < 300; k++) begin
            pct = phase_idle[k / 75];
            case ($urandom_range(3))
                0: val = $urandom;
                1: val = $urandom_range(0, 99);
                2: val = {1'b1, 31'($urandom_range(0, 15))};
                default: val = 32'd0 - 32'($urandom_range(1, 1000));
            endcase
            sel = $urandom_range(9);
            if (sel == 0)
                rad = $urandom_range(1) ? ita_pkg::RADIX_W'($urandom_range(0, 1))
                                        : ita_pkg::RADIX_W'($urandom_range(37, 63));
            else if (sel == 1)
                rad = ita_pkg::RADIX_OCT;
            else if (sel == 2)
                rad = ita_pkg::RADIX_HEX;
            else if (sel == 3)
                rad = 6'd10;
            else
                rad = ita_pkg::RADIX_W'($urandom_range(2, 36));
            queue_request(val, rad,
                          ($urandom_range(7) == 0) ? 6'($urandom_range(49, 63))
                                                   : 6'($urandom_range(0, 48)),
                          ($urandom_range(7) == 0) ? 6'($urandom_range(33, 63))
                                                   : 6'($urandom_range(0, 32)),
                          ita_pkg::FLAGS_W'($urandom_range(127)), pct);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || start || expected_chars.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
